>>> hdl/ps2m_pkg.sv
// shared types, constants and helpers for the ps2 mouse cursor tracker
// no dependencies; imported by the framer, the cursor unit and the top level
`timescale 1ns / 1ps

package ps2m_pkg;

    localparam int POS_BITS_DEF = 12;
    localparam int SIZE_BITS    = 13;
    localparam int BYTE_BITS    = 8;
    localparam int MAG_BITS     = 9;

    localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 13'd1024;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 13'd768;

    // configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // status byte bit positions
    localparam int ST_LEFT   = 0;
    localparam int ST_RIGHT  = 1;
    localparam int ST_MIDDLE = 2;
    localparam int ST_FRAME  = 3;
    localparam int ST_X_SIGN = 4;
    localparam int ST_Y_SIGN = 5;
    localparam int ST_X_OVF  = 6;
    localparam int ST_Y_OVF  = 7;

    localparam logic [MAG_BITS-1:0] OVF_EXTRA = 9'd255;

    // one complete packet from the framer
    typedef struct packed {
        logic                 valid;
        logic [BYTE_BITS-1:0] status;
        logic [BYTE_BITS-1:0] x_byte;
        logic [BYTE_BITS-1:0] y_byte;
    } t_packet;

    // magnitude of a delta byte, including the overflow extension
    function automatic logic [MAG_BITS-1:0] delta_mag(
        input logic [BYTE_BITS-1:0] b,
        input logic                 neg,
        input logic                 ovf
    );
        logic [BYTE_BITS-1:0] m;
        m = neg ? (~b + 8'd1) : b;
        return {1'b0, m} + (ovf ? OVF_EXTRA : '0);
    endfunction

    // size to clamp limit, saturated at top
    function automatic logic [SIZE_BITS-1:0] size_limit(
        input logic [SIZE_BITS-1:0] size,
        input logic [SIZE_BITS-1:0] top
    );
        logic [SIZE_BITS-1:0] lim;
        lim = size - 13'd1;
        if (size == '0) begin
            lim = '0;
        end else if (lim > top) begin
            lim = top;
        end
        return lim;
    endfunction

endpackage

>>> hdl/ps2m_framer.sv
// packet framer: drops the first byte after reset, then frames 3-byte packets
// depends on ps2m_pkg
`timescale 1ns / 1ps

module ps2m_framer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [ps2m_pkg::BYTE_BITS-1:0] i_byte,
    output ps2m_pkg::t_packet           o_packet
);
    import ps2m_pkg::*;

    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_X      = 2'd1;
    localparam logic [1:0] PH_Y      = 2'd2;

    logic [1:0]           r_phase, n_phase;
    logic                 r_first_seen, n_first_seen;
    logic [BYTE_BITS-1:0] r_status, n_status;
    logic [BYTE_BITS-1:0] r_x_byte, n_x_byte;

    always_comb begin
        n_phase      = r_phase;
        n_first_seen = r_first_seen;
        n_status     = r_status;
        n_x_byte     = r_x_byte;
        o_packet     = '{valid: 1'b0, status: r_status, x_byte: r_x_byte, y_byte: i_byte};
        if (i_fire) begin
            if (!r_first_seen) begin
                n_first_seen = 1'b1;
            end else begin
                case (r_phase)
                    PH_X: begin
                        n_x_byte = i_byte;
                        n_phase  = PH_Y;
                    end
                    PH_Y: begin
                        n_phase        = PH_STATUS;
                        o_packet.valid = 1'b1;
                    end
                    default: begin
                        // unused phase acts as status phase; misframed byte dropped
                        if (i_byte[ST_FRAME]) begin
                            n_status = i_byte;
                            n_phase  = PH_X;
                        end else begin
                            n_phase  = PH_STATUS;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_STATUS;
            r_first_seen <= 1'b0;
            r_status     <= '0;
            r_x_byte     <= '0;
        end else begin
            r_phase      <= n_phase;
            r_first_seen <= n_first_seen;
            r_status     <= n_status;
            r_x_byte     <= n_x_byte;
        end
    end

endmodule

>>> hdl/ps2m_cursor.sv
// cursor position unit: applies packet deltas and clamps to the screen
// depends on ps2m_pkg
`timescale 1ns / 1ps

module ps2m_cursor #(
    parameter int POS_BITS = ps2m_pkg::POS_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ps2m_pkg::t_packet   i_packet,
    input  logic                i_commit,
    input  logic [POS_BITS-1:0] i_lim_x,
    input  logic [POS_BITS-1:0] i_lim_y,
    output logic [POS_BITS-1:0] o_next_x,
    output logic [POS_BITS-1:0] o_next_y
);
    import ps2m_pkg::*;

    // room for position plus/minus the largest delta
    localparam int SW = POS_BITS + 4;

    logic [POS_BITS-1:0] r_pos_x, r_pos_y;
    logic [MAG_BITS-1:0] mag_x, mag_y;
    logic signed [SW-1:0] d_x, d_y, s_x, s_y, l_x, l_y;

    always_comb begin
        mag_x = delta_mag(i_packet.x_byte, i_packet.status[ST_X_SIGN],
                          i_packet.status[ST_X_OVF]);
        mag_y = delta_mag(i_packet.y_byte, i_packet.status[ST_Y_SIGN],
                          i_packet.status[ST_Y_OVF]);
        d_x = signed'({{(SW-MAG_BITS){1'b0}}, mag_x});
        d_y = signed'({{(SW-MAG_BITS){1'b0}}, mag_y});
        if (i_packet.status[ST_X_SIGN]) begin
            d_x = -d_x;
        end
        if (i_packet.status[ST_Y_SIGN]) begin
            d_y = -d_y;
        end
        // y axis inverted: downward positive
        s_x = signed'({{(SW-POS_BITS){1'b0}}, r_pos_x}) + d_x;
        s_y = signed'({{(SW-POS_BITS){1'b0}}, r_pos_y}) - d_y;
        l_x = signed'({{(SW-POS_BITS){1'b0}}, i_lim_x});
        l_y = signed'({{(SW-POS_BITS){1'b0}}, i_lim_y});

        if (s_x < 0) begin
            o_next_x = '0;
        end else if (s_x > l_x) begin
            o_next_x = i_lim_x;
        end else begin
            o_next_x = s_x[POS_BITS-1:0];
        end
        if (s_y < 0) begin
            o_next_y = '0;
        end else if (s_y > l_y) begin
            o_next_y = i_lim_y;
        end else begin
            o_next_y = s_y[POS_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else if (i_commit) begin
            r_pos_x <= o_next_x;
            r_pos_y <= o_next_y;
        end
    end

endmodule

>>> hdl/ps2_mouse_cursor_tracker_top.sv
// top level of the ps2 mouse cursor tracker: input stage, framer, cursor unit,
// result register and configuration registers; depends on ps2m_pkg,
// ps2m_framer and ps2m_cursor
//
// usage:
//   s_axis carries one received mouse byte per request in tdata[7:0]. the first
//   byte after reset is dropped, then bytes are framed as status, x, y packets;
//   a status byte must have bit 3 set or it is dropped.
//   m_axis carries one result per completed packet: tdata holds cursor_x,
//   cursor_y, left, right and middle button bits from the lowest bit up.
//   the cfg channel writes screen_width (index 0) and screen_height (index 1);
//   it is always ready and should only be written while the block is idle.
// result path: the third byte is held in the input register, then the framer
//   completes the packet once the result register can advance, raising tvalid.
// throughput: one byte per cycle while m_axis does not stall; the add and clamp
//   path from the input register to the result register is combinational.
// reset: synchronous, active low; clears framing, cursor to 0,0 and the size
//   to 1024 by 768. when m_axis stalls, the result is held, the input register
//   takes one more byte and tready stays low until the result is taken.
`timescale 1ns / 1ps

module ps2_mouse_cursor_tracker_top #(
    parameter int POS_BITS = ps2m_pkg::POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // s_axis tdata: [7:0] data_byte
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // m_axis tdata: cursor_x, cursor_y, left_button, right_button,
    // middle_button, zero fill to whole bytes
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [((2*POS_BITS+3+7)/8)*8-1:0] o_m_axis_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [ps2m_pkg::SIZE_BITS-1:0] i_cfg_data
);
    import ps2m_pkg::*;

    localparam int OUT_W  = ((2*POS_BITS+3+7)/8)*8;
    localparam int PAY_W  = 2*POS_BITS + 3;
    localparam logic [SIZE_BITS-1:0] POS_TOP = SIZE_BITS'((1 << POS_BITS) - 1);

    logic                 r_in_valid;
    logic [BYTE_BITS-1:0] r_in_byte;
    logic                 r_out_valid;
    logic [PAY_W-1:0]     r_out_data;
    logic [POS_BITS-1:0]  r_lim_x, r_lim_y;

    logic                 advance, fire, commit;
    t_packet              packet;
    logic [POS_BITS-1:0]  next_x, next_y;
    logic [SIZE_BITS-1:0] n_lim;

    assign advance         = !r_out_valid || i_m_axis_tready;
    assign fire            = r_in_valid && advance;
    assign commit          = packet.valid;
    assign o_s_axis_tready = advance || !r_in_valid;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-PAY_W){1'b0}}, r_out_data};
    assign n_lim           = size_limit(i_cfg_data, POS_TOP);

    ps2m_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (r_in_byte),
        .o_packet (packet)
    );

    ps2m_cursor #(
        .POS_BITS (POS_BITS)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_packet (packet),
        .i_commit (commit),
        .i_lim_x  (r_lim_x),
        .i_lim_y  (r_lim_y),
        .o_next_x (next_x),
        .o_next_y (next_y)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_data <= {packet.status[ST_MIDDLE], packet.status[ST_RIGHT],
                           packet.status[ST_LEFT], next_y, next_x};
        end
    end

    // clamp limits kept ready instead of raw sizes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_x <= POS_BITS'(size_limit(WIDTH_RST, POS_TOP));
            r_lim_y <= POS_BITS'(size_limit(HEIGHT_RST, POS_TOP));
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_lim_x <= POS_BITS'(n_lim);
                CFG_SCREEN_HEIGHT: r_lim_y <= POS_BITS'(n_lim);
                default: begin
                end
            endcase
        end
    end

    // a new result only comes from a completed packet
    a_out_from_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(packet.valid))
        else $error("result without a completed packet");

    // a packet never completes while the result register is blocked
    a_no_packet_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        packet.valid |-> advance)
        else $error("packet completed during output stall");

    // reported cursor stays within the screen limits
    a_cursor_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data[POS_BITS-1:0] <= r_lim_x) &&
                        (r_out_data[2*POS_BITS-1:POS_BITS] <= r_lim_y))
        else $error("cursor outside screen limits");

    // input is only held off while a byte waits in the input register
    a_ready_low_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_in_valid && r_out_valid && !i_m_axis_tready)
        else $error("input stage stalled without cause");

endmodule
